@@ src/lccp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_pkg: shared types and constants for the LED color command parser
// Request kinds for the result sequencer, line limits, message tables and
// the color wheel.
// ----------------------------------------------------------------------------
package lccp_pkg;

	localparam int LINE_LIMIT  = 64;
	localparam int LEN_W       = $clog2(LINE_LIMIT);
	localparam int STORE_DEPTH = 12;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int NUM_LEDS    = 3;
	localparam int POS_W       = 4;

	localparam logic [7:0] CH_BS    = 8'h7F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BACK  = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] RAINBOW_CMD [STORE_DEPTH] = '{
		8'h23, 8'h46, 8'h55, 8'h4C, 8'h4C, 8'h52,
		8'h41, 8'h49, 8'h4E, 8'h42, 8'h4F, 8'h57
	};

	typedef enum logic [2:0] {
		K_ECHO,
		K_BS,
		K_LEDS,
		K_CR_LEDS,
		K_CR_BAD
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  ch;
		logic [23:0] c6;
		logic [23:0] c7;
		logic [23:0] c8;
	} emit_req_t;

	function automatic logic [7:0] bad_char(input logic [POS_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = 8'h77;
			4'd1:    c = 8'h72;
			4'd2:    c = 8'h6F;
			4'd3:    c = 8'h6E;
			4'd4:    c = 8'h67;
			4'd5:    c = 8'h20;
			4'd6:    c = 8'h66;
			4'd7:    c = 8'h6F;
			4'd8:    c = 8'h72;
			4'd9:    c = 8'h6D;
			4'd10:   c = 8'h61;
			4'd11:   c = 8'h74;
			4'd12:   c = CH_CR;
			4'd13:   c = CH_LF;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [POS_W-1:0] last_pos(input kind_t kind);
		logic [POS_W-1:0] p;
		unique case (kind)
			K_ECHO:    p = POS_W'(0);
			K_BS:      p = POS_W'(2);
			K_LEDS:    p = POS_W'(0);
			K_CR_LEDS: p = POS_W'(2);
			K_CR_BAD:  p = POS_W'(15);
			default:   p = POS_W'(0);
		endcase
		return p;
	endfunction

	function automatic logic [7:0] script_char(input kind_t kind,
			input logic [POS_W-1:0] pos, input logic [7:0] ch);
		logic [7:0] c;
		unique case (kind)
			K_ECHO: c = ch;
			K_BS:   c = (pos == POS_W'(1)) ? CH_SPACE : CH_BACK;
			K_CR_LEDS, K_CR_BAD: begin
				if (pos == POS_W'(0))
					c = CH_CR;
				else if (pos == POS_W'(1))
					c = CH_LF;
				else
					c = bad_char(POS_W'(pos - POS_W'(2)));
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// returns {ok, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] ch);
		logic [4:0] r;
		if (ch >= 8'h30 && ch <= 8'h39)
			r = {1'b1, 4'(ch - 8'h30)};
		else if (ch >= 8'h61 && ch <= 8'h66)
			r = {1'b1, 4'(ch - 8'h57)};
		else
			r = 5'd0;
		return r;
	endfunction

	function automatic logic [23:0] wheel_color(input logic [7:0] pos);
		logic [7:0]  p;
		logic [7:0]  q;
		logic [9:0]  t;
		logic [23:0] c;
		p = ~pos;
		if (p < 8'd85) begin
			t = 10'(p) * 10'd3;
			c = {8'(10'd255 - t), 8'h00, t[7:0]};
		end else if (p < 8'd170) begin
			q = 8'(p - 8'd85);
			t = 10'(q) * 10'd3;
			c = {8'h00, t[7:0], 8'(10'd255 - t)};
		end else begin
			q = 8'(p - 8'd170);
			t = 10'(q) * 10'd3;
			c = {t[7:0], 8'(10'd255 - t), 8'h00};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/lccp_emitter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccp_emitter: result sequencer
// Holds one request and plays out its characters and color push, one result
// per accepted output transfer.
// ----------------------------------------------------------------------------
module lccp_emitter
	import lccp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire emit_req_t   req,
	output logic             free,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic             leds_valid,
	output logic [23:0]      led_six_color,
	output logic [23:0]      led_seven_color,
	output logic [23:0]      led_eight_color,
	output logic             last
);

	logic             em_valid_q;
	emit_req_t        req_q;
	logic [POS_W-1:0] pos_q;
	logic             is_leds;

	assign last      = (pos_q == last_pos(req_q.kind));
	assign out_valid = em_valid_q;
	assign free      = !em_valid_q || (out_ready && last);

	assign is_leds    = (req_q.kind == K_LEDS) ||
		(req_q.kind == K_CR_LEDS && pos_q == POS_W'(2));
	assign leds_valid = is_leds;
	assign tx_valid   = !is_leds;
	assign tx_byte    = is_leds ? 8'h00 : script_char(req_q.kind, pos_q, req_q.ch);
	assign led_six_color   = is_leds ? req_q.c6 : 24'd0;
	assign led_seven_color = is_leds ? req_q.c7 : 24'd0;
	assign led_eight_color = is_leds ? req_q.c8 : 24'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			pos_q      <= '0;
		end else if (load) begin
			em_valid_q <= 1'b1;
			pos_q      <= '0;
		end else if (em_valid_q && out_ready) begin
			if (last)
				em_valid_q <= 1'b0;
			else
				pos_q <= POS_W'(pos_q + POS_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			req_q <= req;
	end

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q |-> pos_q <= last_pos(req_q.kind))
		else $error("sequencer position past end of request");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("request loaded while sequencer busy");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q && is_leds |-> tx_byte == 8'h00)
		else $error("color push carries a character");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		em_valid_q && out_ready && !last && !load |=> em_valid_q &&
			pos_q == POS_W'($past(pos_q) + POS_W'(1)))
		else $error("sequencer did not advance");
`endif

endmodule
`default_nettype wire

@@ src/led_color_command_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_color_command_parser: serial command line editor and LED color control
// Input requests carry a received byte (mode 0) or a 20 ms tick (mode 1).
// Output requests carry either one character to transmit or a push of the
// three LED colors; last marks the final result of an input request.
//
// An accepted request sits in an input register until it can advance; then
// its state update is done and its results are handed to the sequencer,
// which emits one result per cycle while out_ready is high. The first result
// is offered once the request has passed the input register and been loaded
// into the sequencer. While out_ready is high, a request that yields at most
// one result keeps up with one request per cycle; a request with several
// results holds the input side until its last result is taken (up to 16 for a
// rejected line). Requests with no result never wait. When the receiver
// stalls, the current result holds and the input register fills, then
// in_ready drops. Reset clears the line, the stored colors (to black) and the
// color wheel, and empties both stages.
// ----------------------------------------------------------------------------
module led_color_command_parser
	import lccp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             tx_valid,
	output logic [7:0]       tx_byte,
	output logic             leds_valid,
	output logic [23:0]      led_six_color,
	output logic [23:0]      led_seven_color,
	output logic [23:0]      led_eight_color,
	output logic             last
);

	logic             valid_s1;
	logic             mode_s1;
	logic [7:0]       byte_s1;

	logic [7:0]       line_q [STORE_DEPTH];
	logic [LEN_W-1:0] line_len_q;
	logic [23:0]      colors_q [NUM_LEDS];
	logic             rainbow_q;
	logic [7:0]       wheel_q;

	logic             free;
	logic             has_res;
	logic             advance;
	emit_req_t        req;

	logic             rainbow_match;
	logic             color_match;
	logic             len_nine;
	logic [4:0]       hx [6];
	logic             hex_ok;
	logic [23:0]      new_color;
	logic [1:0]       led_sel;
	logic [23:0]      wc_now;
	logic [23:0]      wc_zero;

	logic             set_len;
	logic [LEN_W-1:0] len_d;
	logic             wr_store;
	logic             wr_color;
	logic             set_rainbow;
	logic             rainbow_d;
	logic             set_wheel;
	logic [7:0]       wheel_d;

	always_comb begin
		rainbow_match = (line_len_q == LEN_W'(STORE_DEPTH));
		for (int i = 0; i < STORE_DEPTH; i++)
			if (line_q[i] != RAINBOW_CMD[i])
				rainbow_match = 1'b0;
	end

	always_comb begin
		hex_ok = 1'b1;
		for (int i = 0; i < 6; i++) begin
			hx[i] = hex_val(line_q[i+1]);
			if (!hx[i][4])
				hex_ok = 1'b0;
		end
	end

	assign new_color = {hx[0][3:0], hx[1][3:0], hx[2][3:0],
		hx[3][3:0], hx[4][3:0], hx[5][3:0]};
	assign len_nine  = (line_len_q == LEN_W'(9)) ||
		(line_len_q > LEN_W'(9) && line_q[9] == 8'h00);
	assign color_match = len_nine && line_q[0] == 8'h23 && line_q[7] == 8'h44 &&
		line_q[8] >= 8'h36 && line_q[8] <= 8'h38 && hex_ok;
	assign led_sel = 2'(line_q[8] - 8'h36);
	assign wc_now  = wheel_color(wheel_q);
	assign wc_zero = wheel_color(8'd0);

	always_comb begin
		has_res     = 1'b0;
		req.kind    = K_ECHO;
		req.ch      = byte_s1;
		req.c6      = colors_q[0];
		req.c7      = colors_q[1];
		req.c8      = colors_q[2];
		set_len     = 1'b0;
		len_d       = line_len_q;
		wr_store    = 1'b0;
		wr_color    = 1'b0;
		set_rainbow = 1'b0;
		rainbow_d   = 1'b0;
		set_wheel   = 1'b0;
		wheel_d     = 8'(wheel_q + 8'd1);
		priority if (mode_s1) begin
			if (rainbow_q) begin
				has_res   = 1'b1;
				req.kind  = K_LEDS;
				req.c6    = wc_now;
				req.c7    = wc_now;
				req.c8    = wc_now;
				set_wheel = 1'b1;
			end
		end else if (rainbow_q) begin
			has_res     = 1'b1;
			req.kind    = K_LEDS;
			set_rainbow = 1'b1;
		end else if (byte_s1 == CH_BS) begin
			if (line_len_q != '0) begin
				has_res  = 1'b1;
				req.kind = K_BS;
				set_len  = 1'b1;
				len_d    = LEN_W'(line_len_q - LEN_W'(1));
			end
		end else if (byte_s1 == CH_CR) begin
			has_res = 1'b1;
			set_len = 1'b1;
			len_d   = '0;
			if (rainbow_match) begin
				req.kind    = K_CR_LEDS;
				req.c6      = wc_zero;
				req.c7      = wc_zero;
				req.c8      = wc_zero;
				set_rainbow = 1'b1;
				rainbow_d   = 1'b1;
				set_wheel   = 1'b1;
				wheel_d     = 8'd1;
			end else if (color_match) begin
				req.kind = K_CR_LEDS;
				wr_color = 1'b1;
				if (led_sel == 2'd0) req.c6 = new_color;
				if (led_sel == 2'd1) req.c7 = new_color;
				if (led_sel == 2'd2) req.c8 = new_color;
			end else begin
				req.kind = K_CR_BAD;
			end
		end else begin
			if (line_len_q < LEN_W'(LINE_LIMIT - 1)) begin
				has_res  = 1'b1;
				req.kind = K_ECHO;
				set_len  = 1'b1;
				len_d    = LEN_W'(line_len_q + LEN_W'(1));
				wr_store = (line_len_q < LEN_W'(STORE_DEPTH));
			end
		end
	end

	assign advance  = valid_s1 && (!has_res || free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			line_len_q <= '0;
			rainbow_q  <= 1'b0;
			wheel_q    <= 8'd0;
			for (int i = 0; i < NUM_LEDS; i++)
				colors_q[i] <= 24'd0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				if (set_len)
					line_len_q <= len_d;
				if (set_rainbow)
					rainbow_q <= rainbow_d;
				if (set_wheel)
					wheel_q <= wheel_d;
				if (wr_color)
					colors_q[led_sel] <= new_color;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
		if (advance && wr_store)
			line_q[line_len_q[STORE_AW-1:0]] <= byte_s1;
	end

	lccp_emitter u_emitter (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (advance && has_res),
		.req             (req),
		.free            (free),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.leds_valid      (leds_valid),
		.led_six_color   (led_six_color),
		.led_seven_color (led_seven_color),
		.led_eight_color (led_eight_color),
		.last            (last)
	);

endmodule
`default_nettype wire

@@ tb/led_color_command_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_color_command_parser_tb: self-checking bench for the LED command parser
// A short table of directed requests (reset state, empty-line backspace, zero
// byte, wheel start and stop) is followed by random command sessions: color
// commands, wheel sessions, noise lines, tick bursts, backspace edits and
// overlong lines. Every result is compared with a local model of the parser,
// under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module led_color_command_parser_tb
	import lccp_pkg::*;
();

	localparam bit MODE_BYTE = 1'b0;
	localparam bit MODE_TICK = 1'b1;
	localparam int NO_TYPED = -1;
	localparam int RANDOM_ITEMS = 255;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS = 10;
	localparam string RAINBOW_TEXT = "#FULLRAINBOW";
	localparam string BAD_TEXT = "wrong format";
	localparam string HEX_DIGITS = "0123456789abcdef";

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        leds_valid;
		logic [23:0] c6;
		logic [23:0] c7;
		logic [23:0] c8;
		logic        last;
	} led_result_t;

	typedef struct {
		bit          m;
		logic [7:0]  ch;
		int          typed_n;
		led_result_t typed_res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        leds_valid;
	logic [23:0] led_six_color;
	logic [23:0] led_seven_color;
	logic [23:0] led_eight_color;
	logic        last;

	led_color_command_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.leds_valid(leds_valid),
		.led_six_color(led_six_color),
		.led_seven_color(led_seven_color),
		.led_eight_color(led_eight_color),
		.last(last)
	);

	// parser model state
	logic [7:0]  line_buf [STORE_DEPTH];
	int          line_len;
	logic [23:0] saved_color [3];
	bit          wheel_on;
	logic [7:0]  wheel_pos;

	led_result_t step_results[$];
	led_result_t pending_results[$];
	int          mismatches;
	int          sent_items;
	int          gap_pct;
	int          stall_pct;
	bit          hold_off_req;
	stim_row_t   directed_rows [23];

	function automatic led_result_t char_result(input logic [7:0] c, input bit fin = 1'b0);
		return '{1'b1, c, 1'b0, 24'h0, 24'h0, 24'h0, fin};
	endfunction

	function automatic led_result_t leds_result(input logic [23:0] a, input logic [23:0] b,
			input logic [23:0] c, input bit fin = 1'b0);
		return '{1'b0, 8'h00, 1'b1, a, b, c, fin};
	endfunction

	function automatic stim_row_t row(input bit m, input logic [7:0] ch,
			input int n = NO_TYPED, input led_result_t res = '0);
		stim_row_t r;
		r.m = m;
		r.ch = ch;
		r.typed_n = n;
		r.typed_res = res;
		return r;
	endfunction

	function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
		int p;
		p = 255 - int'(pos);
		if (p < 85)
			return {8'(255 - 3 * p), 8'h00, 8'(3 * p)};
		if (p < 170) begin
			p -= 85;
			return {8'h00, 8'(3 * p), 8'(255 - 3 * p)};
		end
		p -= 170;
		return {8'(3 * p), 8'(255 - 3 * p), 8'h00};
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c) - int'("0");
		if (c >= "a" && c <= "f")
			return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	// applies one request to the model; results land in step_results
	task automatic advance_parser(input bit m, input logic [7:0] b);
		logic [23:0] c;
		logic [23:0] color;
		int          len;
		int          lim;
		int          d;
		bit          ok;
		bit          handled;
		step_results.delete();
		if (m == MODE_TICK) begin
			if (wheel_on) begin
				c = wheel_rgb(wheel_pos);
				step_results.push_back(leds_result(c, c, c));
				wheel_pos++;
			end
		end else if (wheel_on) begin
			wheel_on = 1'b0;
			step_results.push_back(leds_result(saved_color[0], saved_color[1], saved_color[2]));
		end else if (b == CH_BS) begin
			if (line_len > 0) begin
				line_len--;
				step_results.push_back(char_result(CH_BACK));
				step_results.push_back(char_result(CH_SPACE));
				step_results.push_back(char_result(CH_BACK));
			end
		end else if (b == CH_CR) begin
			step_results.push_back(char_result(CH_CR));
			step_results.push_back(char_result(CH_LF));
			len = line_len;
			lim = (line_len < STORE_DEPTH) ? line_len : STORE_DEPTH;
			for (int i = 0; i < lim; i++) begin
				if (line_buf[i] == 8'h00) begin
					len = i;
					break;
				end
			end
			handled = 1'b0;
			if (len == STORE_DEPTH) begin
				ok = 1'b1;
				for (int i = 0; i < STORE_DEPTH; i++)
					if (line_buf[i] != RAINBOW_TEXT[i])
						ok = 1'b0;
				if (ok) begin
					wheel_on = 1'b1;
					c = wheel_rgb(8'd0);
					step_results.push_back(leds_result(c, c, c));
					wheel_pos = 8'd1;
					handled = 1'b1;
				end
			end
			if (!handled && len == 9 && line_buf[0] == "#" && line_buf[7] == "D" &&
					line_buf[8] >= "6" && line_buf[8] <= "8") begin
				ok = 1'b1;
				color = 24'h0;
				for (int i = 1; i < 7; i++) begin
					d = hex_nibble(line_buf[i]);
					if (d < 0)
						ok = 1'b0;
					else
						color = {color[19:0], 4'(d)};
				end
				if (ok) begin
					saved_color[int'(line_buf[8]) - int'("6")] = color;
					step_results.push_back(leds_result(saved_color[0], saved_color[1],
						saved_color[2]));
					handled = 1'b1;
				end
			end
			if (!handled) begin
				for (int i = 0; i < BAD_TEXT.len(); i++)
					step_results.push_back(char_result(BAD_TEXT[i]));
				step_results.push_back(char_result(CH_CR));
				step_results.push_back(char_result(CH_LF));
			end
			line_len = 0;
		end else if (line_len < LINE_LIMIT - 1) begin
			if (line_len < STORE_DEPTH)
				line_buf[line_len] = b;
			line_len++;
			step_results.push_back(char_result(b));
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input led_result_t want,
			input led_result_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display({"%0t %s: exp tx=%b/%h leds=%b %h %h %h last=%b,",
				" got tx=%b/%h leds=%b %h %h %h last=%b"},
				$realtime, what,
				want.tx_valid, want.tx_byte, want.leds_valid, want.c6, want.c7, want.c8,
				want.last,
				got.tx_valid, got.tx_byte, got.leds_valid, got.c6, got.c7, got.c8, got.last);
	endtask

	task automatic set_idle_phase(input int p);
		case (p)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 47; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 47; end
			default: begin gap_pct = 28; stall_pct = 28; end
		endcase
	endtask

	// offers one request and records its expected results once accepted
	task automatic send_request(input bit m, input logic [7:0] b,
			input int typed_n = NO_TYPED, input led_result_t typed_res = '0);
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		rx_byte = b;
		do
			@(posedge clk);
		while (!in_ready);
		advance_parser(m, b);
		sent_items++;
		if (typed_n == NO_TYPED) begin
			foreach (step_results[i])
				pending_results.push_back(step_results[i]);
		end else if (typed_n > 0) begin
			pending_results.push_back(typed_res);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_request(MODE_BYTE, s[i]);
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_request(MODE_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_color_command();
		int          style;
		logic [7:0]  c;
		style = $urandom_range(0, 9);
		send_request(MODE_BYTE, "#");
		for (int k = 0; k < 6; k++) begin
			if (style == 0)
				c = "f";
			else if (style == 1)
				c = "0";
			else
				c = HEX_DIGITS[$urandom_range(0, 15)];
			if ($urandom_range(0, 99) < 4)
				c = 8'($urandom_range(0, 255));
			send_request(MODE_BYTE, c);
		end
		if ($urandom_range(0, 99) < 10) begin
			send_request(MODE_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
			send_request(MODE_BYTE, CH_BS);
		end
		send_request(MODE_BYTE, ($urandom_range(0, 99) < 5) ? 8'("d") : 8'("D"));
		if ($urandom_range(0, 99) < 5)
			send_request(MODE_BYTE, 8'($urandom_range(8'h30, 8'h39)));
		else
			send_request(MODE_BYTE, 8'(int'("6") + $urandom_range(0, 2)));
		// zero byte cuts the line before trailing junk
		if ($urandom_range(0, 99) < 10) begin
			send_request(MODE_BYTE, 8'h00);
			repeat ($urandom_range(0, 4))
				send_request(MODE_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
		end
		send_request(MODE_BYTE, CH_CR);
	endtask

	task automatic send_wheel_session(input int ticks);
		int bad_at;
		bad_at = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 11) : -1;
		for (int i = 0; i < RAINBOW_TEXT.len(); i++)
			send_request(MODE_BYTE, (i == bad_at) ? 8'($urandom_range(0, 255))
				: 8'(RAINBOW_TEXT[i]));
		send_request(MODE_BYTE, CH_CR);
		send_ticks(ticks);
		send_request(MODE_BYTE, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES)
					@(negedge clk);
				hold_off_req = 1'b0;
			end
			out_ready = ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		led_result_t got;
		led_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got = '{tx_valid, tx_byte, leds_valid, led_six_color, led_seven_color,
					led_eight_color, last};
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want)
						report_mismatch("result mismatch", want, got);
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t timeout, %0d results outstanding", $realtime,
					pending_results.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		int seq;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_BYTE;
		rx_byte = 8'h00;
		hold_off_req = 1'b0;
		mismatches = 0;
		sent_items = 0;
		line_len = 0;
		saved_color = '{24'h0, 24'h0, 24'h0};
		wheel_on = 1'b0;
		wheel_pos = 8'd0;
		set_idle_phase(0);

		directed_rows = '{
			row(MODE_TICK, 8'hFF, 0),
			row(MODE_BYTE, CH_BS, 0),
			row(MODE_BYTE, 8'h00, 1, char_result(8'h00, 1'b1)),
			row(MODE_BYTE, CH_CR),
			row(MODE_BYTE, "#"), row(MODE_BYTE, "F"), row(MODE_BYTE, "U"),
			row(MODE_BYTE, "L"), row(MODE_BYTE, "L"), row(MODE_BYTE, "R"),
			row(MODE_BYTE, "A"), row(MODE_BYTE, "I"), row(MODE_BYTE, "N"),
			row(MODE_BYTE, "B"), row(MODE_BYTE, "O"), row(MODE_BYTE, "W"),
			row(MODE_BYTE, CH_CR),
			row(MODE_TICK, 8'h00),
			row(MODE_BYTE, 8'h55, 1, leds_result(24'h0, 24'h0, 24'h0, 1'b1)),
			row(MODE_BYTE, 8'hFF, 1, char_result(8'hFF, 1'b1)),
			row(MODE_BYTE, CH_BS),
			row(MODE_BYTE, CH_BS, 0),
			row(MODE_BYTE, CH_CR)
		};

		repeat (8)
			@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].m, directed_rows[i].ch, directed_rows[i].typed_n,
				directed_rows[i].typed_res);

		// receiver holds off while requests keep coming
		hold_off_req = 1'b1;
		seq = 0;
		while (sent_items < $size(directed_rows) + RANDOM_ITEMS) begin
			set_idle_phase((seq / 5) % 4);
			kind = (seq == 3) ? 99 : $urandom_range(0, 99);
			if (kind < 35) begin
				send_color_command();
			end else if (kind < 50) begin
				send_wheel_session($urandom_range(0, 6));
			end else if (kind < 65) begin
				repeat ($urandom_range(0, 15))
					send_request(MODE_BYTE, 8'($urandom_range(0, 255)));
				send_request(MODE_BYTE, CH_CR);
			end else if (kind < 80) begin
				send_ticks($urandom_range(1, 4));
			end else if (kind < 96) begin
				repeat ($urandom_range(0, 4))
					send_request(MODE_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
				repeat ($urandom_range(1, 6))
					send_request(MODE_BYTE, CH_BS);
				send_request(MODE_BYTE, CH_CR);
			end else begin
				// overlong line: store overflow, and dropped characters past the line limit
				repeat ($urandom_range(55, 75))
					send_request(MODE_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
				send_request(MODE_BYTE, CH_CR);
			end
			seq++;
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
